/* design/ubd_pkg.sv */
// Package for the unsigned-to-base-digits converter: state encoding,
// control/status structs, digit glyph and base clamp helpers.
// No dependencies.
`default_nettype none

package ubd_pkg;

  // Widths fixed by the register and the digit format
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;
  // Dividend bits consumed by the divider per cycle
  localparam int STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_A  = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LOAD,
    ST_SEND
  } state_t;

  // Top level to divider
  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] base;
  } div_ctrl_t;

  // Divider to top level
  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  // Clamp the register to a usable base: below two acts as two, above sixteen as sixteen
  function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] radix);
    logic [RADIX_W-1:0] b;
    b = radix;
    if (radix < BASE_MIN) begin
      b = BASE_MIN;
    end else if (radix > BASE_MAX) begin
      b = BASE_MAX;
    end
    return b;
  endfunction

  // Digit value to ASCII: 0-9 then lower-case a-f
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOW_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/unsigned_to_base_digits_unit.sv */
// Unsigned-to-base-digits converter: one value in, its digits out MSB first.
// All digits are first produced by the shared divider, four value bits per step; emission
// then takes each through the read, load and send states, waiting in send for out_tready.
// One item at a time.
// Synchronous active-low reset: idle, radix 10; the digit store is not cleared.
// Depends on ubd_pkg and ubd_divider.
`default_nettype none

module unsigned_to_base_digits_unit #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration: radix
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [ubd_pkg::RADIX_W-1:0]  cfg_data,
  // Input stream
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [63:0]                  in_tdata,   // [63:0] number_in
  // Result stream
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [7:0]                   out_tdata,  // [6:0] digit_char, [7] zero
  output logic                         out_tlast   // last_digit
);
  import ubd_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int TW = $clog2(MAX_DIGITS + 1);

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic [TW-1:0]      total_r, total_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0] rd_data_r;
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_value;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  logic          in_acc;
  logic          out_acc;
  logic          mem_we;
  logic          finish;
  logic [TW-1:0] total_inc;

  ubd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (div_ctrl),
    .value_i (div_value),
    .stat_o  (div_stat),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign total_inc = total_r + TW'(1);
  assign finish    = div_stat.quot_zero || (total_inc == TW'(MAX_DIGITS));
  assign mem_we    = (state_r == ST_DIV) && div_stat.done;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done && finish) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_tready) state_nxt = out_last_r ? ST_IDLE : ST_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    div_ctrl.base  = eff_base(radix_r);
    div_ctrl.start = in_acc || (mem_we && !finish);
    div_value      = (state_r == ST_IDLE) ? in_tdata[VALUE_BITS-1:0] : div_quot;

    total_nxt     = total_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (in_acc) begin
      total_nxt = '0;
    end
    if (mem_we) begin
      total_nxt = total_inc;
      if (finish) rd_ptr_nxt = total_r[AW-1:0];
    end
    if (state_r == ST_LOAD) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = glyph(rd_data_r);
      out_last_nxt  = (rd_ptr_r == '0);
    end
    if (out_acc) begin
      out_valid_nxt = 1'b0;
      if (!out_last_r) rd_ptr_nxt = rd_ptr_r - AW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) radix_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit store, least significant digit at index zero
  always_ff @(posedge clk) begin
    if (mem_we) digit_mem[total_r[AW-1:0]] <= div_rem;
    rd_data_r <= digit_mem[rd_ptr_r];
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A result beat is offered only in the send state
  a_valid_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == ST_SEND))
    else $error("result valid outside send state");
  // Digit count never passes the store depth
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(MAX_DIGITS))
    else $error("digit count beyond store depth");
  // Leaving division always starts emission from the top digit
  a_div_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && finish) |=> (state_r == ST_RD && TW'(rd_ptr_r) == total_r - TW'(1)))
    else $error("emission does not start at most significant digit");
  // The last beat returns the block to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (state_r == ST_IDLE))
    else $error("block not idle after last digit");
`endif

endmodule

`default_nettype wire

/* design/ubd_divider.sv */
// Iterative divider: divides a value by a small base (2..16), four dividend
// bits per cycle, giving quotient and remainder. Depends on ubd_pkg.
`default_nettype none

module ubd_divider #(
  parameter int VALUE_BITS = 64
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  ubd_pkg::div_ctrl_t            ctrl_i,
  input  wire  [VALUE_BITS-1:0]         value_i,
  output ubd_pkg::div_stat_t            stat_o,
  output logic [VALUE_BITS-1:0]         quot_o,
  output logic [ubd_pkg::DIGIT_W-1:0]   rem_o
);
  import ubd_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD    = CHUNKS * STEP_BITS;
  localparam int CW     = $clog2(CHUNKS + 1);

  logic [PAD-1:0]     acc_r, acc_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] base_r, base_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               done_r, done_nxt;

  logic [RADIX_W-1:0]   part;
  logic [RADIX_W-1:0]   trial;
  logic [STEP_BITS-1:0] qbits;

  // One radix-16 step: four restoring subtract steps on a 5-bit partial remainder
  always_comb begin
    part  = RADIX_W'(rem_r);
    trial = '0;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {part[DIGIT_W-1:0], acc_r[PAD-1-i]};
      if (trial >= base_r) begin
        trial = trial - base_r;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      part = trial;
    end
  end

  // Next values: load on start, step while count runs
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    base_nxt = base_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctrl_i.start) begin
      acc_nxt  = PAD'(value_i);
      rem_nxt  = '0;
      base_nxt = ctrl_i.base;
      cnt_nxt  = CW'(CHUNKS);
    end else if (cnt_r != '0) begin
      acc_nxt  = {acc_r[PAD-STEP_BITS-1:0], qbits};
      rem_nxt  = part[DIGIT_W-1:0];
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
  end

  assign quot_o           = acc_r[VALUE_BITS-1:0];
  assign rem_o            = rem_r;
  assign stat_o.done      = done_r;
  assign stat_o.quot_zero = (acc_r == '0);

`ifndef SYNTHESIS
  // Done pulses in the cycle after the last step
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(1) && !ctrl_i.start) |=> done_r)
    else $error("divider done missing after last step");
  // Remainder always below the base once a division completes
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (RADIX_W'(rem_r) < base_r))
    else $error("divider remainder not below base");
  // Count never exceeds the chunk count
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CHUNKS))
    else $error("divider count out of range");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for unsigned_to_base_digits_unit: random and directed numbers
// go in, digit characters come out MSB first and are checked against a model.
// Depends on ubd_pkg and the design sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ubd_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 134;

  // Expected digit stream for the converter: one entry per output beat
  class digit_scoreboard;
    logic [RADIX_W-1:0] radix_reg;
    logic [CHAR_W:0]    digit_q[$];  // {last_digit, digit_char}
    int                 errors;

    function new();
      radix_reg = RADIX_RESET;
      errors    = 0;
    endfunction

    function void set_radix(input logic [RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    function int outstanding();
      return digit_q.size();
    endfunction

    // Split an accepted number into digits and queue their characters
    function void note_number(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] base;
      logic [3:0]  digs[$];
      logic [3:0]  d;
      logic [CHAR_W-1:0] ch;
      int k;
      if (radix_reg < BASE_MIN) begin
        base = 64'(BASE_MIN);
      end else if (radix_reg > BASE_MAX) begin
        base = 64'(BASE_MAX);
      end else begin
        base = 64'(radix_reg);
      end
      rem = value;
      if (rem == 64'd0) begin
        digs.push_front(4'd0);
      end
      while (rem != 64'd0 && digs.size() < 64) begin
        digs.push_front(4'(rem % base));
        rem = rem / base;
      end
      for (k = 0; k < digs.size(); k++) begin
        d = digs[k];
        ch = (d < 4'd10) ? 7'(8'd48 + d) : 7'(8'd97 + d - 4'd10);
        digit_q.push_back({(k == digs.size() - 1), ch});
      end
    endfunction

    // Compare one accepted result beat with the oldest expected digit
    function void check_digit(input logic [7:0] data, input logic last);
      logic [CHAR_W:0] want;
      if (digit_q.size() == 0) begin
        $display("%0t: unexpected digit beat, data %h last %b", $time, data, last);
        errors++;
        return;
      end
      want = digit_q.pop_front();
      if (data[CHAR_W-1:0] !== want[CHAR_W-1:0]) begin
        $display("%0t: digit_char mismatch, expected %h actual %h",
                 $time, want[CHAR_W-1:0], data[CHAR_W-1:0]);
        errors++;
      end
      if (data[7] !== 1'b0) begin
        $display("%0t: tdata pad bit mismatch, expected 0 actual %b", $time, data[7]);
        errors++;
      end
      if (last !== want[CHAR_W]) begin
        $display("%0t: last_digit mismatch, expected %b actual %b",
                 $time, want[CHAR_W], last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [RADIX_W-1:0]  cfg_data   = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [63:0]         in_tdata   = '0;  // [63:0] number_in
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;        // [6:0] digit_char, [7] zero
  logic                out_tlast;        // last_digit

  digit_scoreboard digits = new();
  bit  no_idle   = 1'b0;
  int  hold_req  = 0;
  int  hold_done = 0;
  int  cycles    = 0;

  unsigned_to_base_digits_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one number, optionally after a random gap, and wait until it is accepted
  task automatic send_number(input logic [63:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    digits.note_number(value);
  endtask

  // Hold the input off until every queued digit has come out, plus a tail
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digits.outstanding() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Radix write, only with the converter idle
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    digits.set_radix(r);
  endtask

  // Random 64-bit value with a random bit length, so short numbers are common
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int w;
    w = $urandom_range(0, 64);
    v = {$urandom, $urandom};
    if (w < 64) begin
      v = v & ((64'd1 << w) - 64'd1);
    end
    return v;
  endfunction

  // Result side: random stalls, one long hold when the stimulus asks for it
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      digits.check_digit(out_tdata, out_tlast);
    end
  end

  // Stimulus
  initial begin
    logic [RADIX_W-1:0] r;
    int sent;
    int n;
    int phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radix (decimal): zero, single digits, carries, extremes
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd100);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'd12345678901234567890);

    // Binary: longest digit run
    write_radix(5'd2);
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);

    // Hex: every glyph including a-f
    write_radix(5'd16);
    send_number(64'd15);
    send_number(64'd16);
    send_number(64'hFEDC_BA98_7654_3210);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);

    // Radix below two acts as binary
    write_radix(5'd0);
    send_number(64'd5);
    write_radix(5'd1);
    send_number(64'd6);

    // Radix above sixteen acts as hex
    write_radix(5'd31);
    send_number(64'h0123_4567_89AB_CDEF);
    write_radix(5'd17);
    send_number(64'd255);

    // Odd bases
    write_radix(5'd3);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    write_radix(5'd15);
    send_number(64'd224);

    // Random phases, each with its own radix
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       r = 5'd2;
        1:       r = 5'd16;
        2:       r = 5'($urandom_range(0, 31));
        default: r = 5'($urandom_range(3, 15));
      endcase
      write_radix(r);
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        no_idle = 1'b0;
        hold_req++;
      end
      n = $urandom_range(4, 16);
      repeat (n) begin
        send_number(rand_value());
      end
      sent += n;
      phase++;
    end

    // Let the last digits drain, then report
    no_idle = 1'b0;
    wait_drained();
    if (digits.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ubd_pkg.sv
design/ubd_divider.sv
design/unsigned_to_base_digits_unit.sv
dv/testbench.sv
